// ----- sv/smooth_escape_color_palette_defines.svh -----
// assertion helpers shared by the rtl
`ifndef SMOOTH_ESCAPE_COLOR_PALETTE_DEFINES_SVH
`define SMOOTH_ESCAPE_COLOR_PALETTE_DEFINES_SVH

// same-cycle implication, reset masks the check
`define SECP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset masks the check
`define SECP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/secp_pkg.sv -----
`default_nettype none
package secp_pkg;

  localparam int unsigned FRAC        = 30;
  localparam int unsigned MAX_ITER_DEF = 256;
  localparam int unsigned LOG_W       = 37;

  localparam logic [30:0] ONE_Q30      = 31'h4000_0000;
  localparam logic [29:0] HALF_Q30     = 30'h2000_0000;
  localparam logic [28:0] HALF_LN2_Q30 = 29'd372130559;
  localparam logic [31:0] PI_Q30       = 32'd3373259426;
  localparam logic [29:0] BLUE_OFS     = 30'd178956971;
  localparam logic [32:0] FOUR_Q16     = 33'h0_0004_0000;

  // reciprocals for exact floor division of a 32-bit value
  localparam int unsigned SH_110 = 39;
  localparam int unsigned SH_72  = 39;
  localparam int unsigned SH_42  = 38;
  localparam int unsigned SH_20  = 37;
  localparam int unsigned SH_6   = 35;

  localparam logic [32:0] RCP_110 = 33'(((64'd1 << SH_110) + 64'd109) / 64'd110);
  localparam logic [32:0] RCP_72  = 33'(((64'd1 << SH_72) + 64'd71) / 64'd72);
  localparam logic [32:0] RCP_42  = 33'(((64'd1 << SH_42) + 64'd41) / 64'd42);
  localparam logic [32:0] RCP_20  = 33'(((64'd1 << SH_20) + 64'd19) / 64'd20);
  localparam logic [32:0] RCP_6   = 33'(((64'd1 << SH_6) + 64'd5) / 64'd6);

  localparam logic [7:0] AMP [3] = '{8'd192, 8'd96, 8'd192};

  function automatic logic [33:0] mul_q30(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] prod;
    prod = 64'(a) * 64'(b);
    return 34'(prod >> FRAC);
  endfunction

  function automatic logic [31:0] div_rcp(input logic [31:0] n, input logic [32:0] m,
                                          input int unsigned sh);
    logic [64:0] prod;
    prod = 65'(n) * 65'(m);
    return 32'(prod >> sh);
  endfunction

endpackage
`default_nettype wire

// ----- sv/secp_log2.sv -----
`default_nettype none
module secp_log2 import secp_pkg::*; #(
  parameter int unsigned W   = 33,
  parameter int unsigned FIN = 16,
  parameter int unsigned TW  = 10
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    en_i,
  input  wire logic                    vld_i,
  input  wire logic [W-1:0]            x_i,
  input  wire logic [TW-1:0]           tag_i,
  output logic                         vld_o,
  output logic signed [LOG_W-1:0]      log_o,
  output logic [TW-1:0]                tag_o
);

  localparam int unsigned NST = FRAC;

  logic [30:0]    y_q   [0:NST];
  logic [5:0]     p_q   [0:NST];
  logic           z_q   [0:NST];
  logic [TW-1:0]  tag_q [0:NST];
  logic [29:0]    fr_q  [0:NST];
  logic           vld_q [0:NST];

  logic [5:0]  p_d;
  logic [63:0] ext;
  logic [63:0] y_ext;

  always_comb begin
    p_d = '0;
    for (int i = 0; i < W; i++) begin
      if (x_i[i]) begin
        p_d = 6'(i);
      end
    end
    ext = 64'(x_i);
    if (p_d > 6'(FRAC)) begin
      y_ext = ext >> (p_d - 6'(FRAC));
    end else begin
      y_ext = ext << (6'(FRAC) - p_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= NST; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (en_i) begin
      vld_q[0] <= vld_i;
      for (int k = 1; k <= NST; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y_q[0]   <= y_ext[30:0];
      p_q[0]   <= p_d;
      z_q[0]   <= (x_i == '0);
      tag_q[0] <= tag_i;
      fr_q[0]  <= '0;
    end
  end

  for (genvar k = 1; k <= NST; k++) begin : g_sq
    logic [33:0] yy;
    assign yy = mul_q30(32'(y_q[k-1]), 32'(y_q[k-1]));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        p_q[k]   <= p_q[k-1];
        z_q[k]   <= z_q[k-1];
        tag_q[k] <= tag_q[k-1];
        if (yy[31]) begin
          y_q[k]  <= yy[31:1];
          fr_q[k] <= fr_q[k-1] | (30'(1) << (NST - k));
        end else begin
          y_q[k]  <= yy[30:0];
          fr_q[k] <= fr_q[k-1];
        end
      end
    end
  end

  logic signed [6:0] ip;
  assign ip    = $signed({1'b0, p_q[NST]}) - 7'(FIN);
  assign log_o = z_q[NST] ? '0 : $signed({ip, fr_q[NST]});
  assign vld_o = vld_q[NST];
  assign tag_o = tag_q[NST];

endmodule
`default_nettype wire

// ----- sv/smooth_escape_color_palette.sv -----
// channel       dir  handshake                       payload
// s_axis        in   s_axis_tvalid / s_axis_tready   count, real_square, imag_square
// m_axis        out  m_axis_tvalid / m_axis_tready   pixel_color
// cfg           in   cfg_valid_i / cfg_ready_o       phase_offset
// one pixel per cycle in while m_axis is not stalled
// the pipeline holds the two 30-step pipelined log2 square chains and the sine lanes
// reset clears every valid bit and phase_offset, payload registers are not reset
// a stall on m_axis freezes the whole pipeline, s_axis_tready drops with it
`default_nettype none
`include "smooth_escape_color_palette_defines.svh"
module smooth_escape_color_palette import secp_pkg::*; #(
  parameter int unsigned MAX_ITER = MAX_ITER_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [79:0] s_axis_tdata,  // iteration_count, real_square, imag_square, zeros
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // pixel_color
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i
);

  localparam int unsigned NW = $clog2(2 * MAX_ITER + 514) + 31;
  localparam logic [NW-1:0] N_BIAS = NW'(2 * MAX_ITER) << FRAC;
  localparam logic [16:0] INT_CODE = 17'(MAX_ITER + 3);
  localparam int unsigned LN = 13;

  logic en;
  logic [15:0] phase_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (cfg_valid_i) begin
      phase_q <= cfg_data_i;
    end
  end

  logic vo_q;
  assign en            = !vo_q || m_axis_tready;
  assign s_axis_tready = en;

  // sum and clamp
  logic [8:0]  cnt_in;
  logic [32:0] sum;
  logic [32:0] s_q;
  logic [9:0]  ta_q;
  logic        va_q;

  assign cnt_in = s_axis_tdata[8:0];
  assign sum    = 33'(s_axis_tdata[40:9]) + 33'(s_axis_tdata[72:41]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      s_q  <= (sum < FOUR_Q16) ? FOUR_Q16 : sum;
      ta_q <= {(17'(cnt_in) == INT_CODE), cnt_in};
    end
  end

  // log2 of squared magnitude
  logic                    v1;
  logic signed [LOG_W-1:0] l1;
  logic [9:0]              t1;

  secp_log2 #(.W(33), .FIN(16), .TW(10)) u_log_mag (
    .clk_i, .rst_ni, .en_i(en), .vld_i(va_q), .x_i(s_q), .tag_i(ta_q),
    .vld_o(v1), .log_o(l1), .tag_o(t1)
  );

  // ln|z|
  logic [33:0] m_q;
  logic [9:0]  tb_q;
  logic        vb_q;
  logic [63:0] m_prod;

  assign m_prod = 64'(l1[34:0]) * 64'(HALF_LN2_Q30);

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_q  <= 34'(m_prod >> FRAC);
      tb_q <= t1;
    end
  end

  logic                    v2;
  logic signed [LOG_W-1:0] lz;
  logic [9:0]              t2;

  secp_log2 #(.W(34), .FIN(FRAC), .TW(10)) u_log_ln (
    .clk_i, .rst_ni, .en_i(en), .vld_i(vb_q), .x_i(m_q), .tag_i(tb_q),
    .vld_o(v2), .log_o(lz), .tag_o(t2)
  );

  // grade
  logic [NW-1:0] n_q;
  logic [30:0]   g0_q;
  logic [30:0]   g_q;
  logic          ic_q, id_q, ie_q;
  logic          vc_q, vd_q, ve_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      n_q  <= ((NW'(t2[8:0]) + NW'(1)) << FRAC) + N_BIAS - NW'(lz);
      ic_q <= t2[9];
      g0_q <= 31'(n_q / NW'(MAX_ITER));
      id_q <= ic_q;
      g_q  <= g0_q + {phase_q, 15'b0};
      ie_q <= id_q;
    end
  end

  // per-channel half-turn phase
  logic [29:0] t_lane [3];
  logic [35:0] g25;
  logic [33:0] g6;

  assign g25       = 36'(g_q) * 36'd25;
  assign g6        = 34'(g_q) * 34'd6;
  assign t_lane[0] = g25[30:1];
  assign t_lane[1] = g6[29:0];
  assign t_lane[2] = 30'({g_q, 3'b000}) + BLUE_OFS;

  logic vl_q [0:LN-1];
  logic il_q [0:LN-1];
  logic [7:0] chan [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
      vo_q <= 1'b0;
      for (int k = 0; k < LN; k++) begin
        vl_q[k] <= 1'b0;
      end
    end else if (en) begin
      va_q    <= s_axis_tvalid;
      vb_q    <= v1;
      vc_q    <= v2;
      vd_q    <= vc_q;
      ve_q    <= vd_q;
      vl_q[0] <= ve_q;
      for (int k = 1; k < LN; k++) begin
        vl_q[k] <= vl_q[k-1];
      end
      vo_q <= vl_q[LN-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      il_q[0] <= ie_q;
      for (int k = 1; k < LN; k++) begin
        il_q[k] <= il_q[k-1];
      end
    end
  end

  // sine lanes: fold, x, x^2, horner to x^11, cap, scale
  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic [30:0] tf;
    logic [30:0] xs_q [0:10];
    logic [31:0] xx_q [1:8];
    logic [31:0] w_q  [2:11];
    logic [7:0]  c_q;
    logic [33:0] sq;
    logic [33:0] sv;
    logic [39:0] cp;

    assign tf = (t_lane[l] > HALF_Q30) ? (ONE_Q30 - 31'(t_lane[l])) : 31'(t_lane[l]);
    assign sq = mul_q30(32'(xs_q[0]), 32'(xs_q[0]));
    assign sv = mul_q30(32'(xs_q[10]), w_q[10]);
    assign cp = 40'(AMP[l]) * 40'(w_q[11]);

    always_ff @(posedge clk_i) begin
      if (en) begin
        xs_q[0] <= 31'(mul_q30(32'(tf), PI_Q30));
        for (int k = 1; k <= 10; k++) begin
          xs_q[k] <= xs_q[k-1];
        end
        xx_q[1] <= 32'(sq);
        for (int k = 2; k <= 8; k++) begin
          xx_q[k] <= xx_q[k-1];
        end
        w_q[2]  <= 32'(ONE_Q30) - div_rcp(xx_q[1], RCP_110, SH_110);
        w_q[3]  <= 32'(mul_q30(xx_q[2], w_q[2]));
        w_q[4]  <= 32'(ONE_Q30) - div_rcp(w_q[3], RCP_72, SH_72);
        w_q[5]  <= 32'(mul_q30(xx_q[4], w_q[4]));
        w_q[6]  <= 32'(ONE_Q30) - div_rcp(w_q[5], RCP_42, SH_42);
        w_q[7]  <= 32'(mul_q30(xx_q[6], w_q[6]));
        w_q[8]  <= 32'(ONE_Q30) - div_rcp(w_q[7], RCP_20, SH_20);
        w_q[9]  <= 32'(mul_q30(xx_q[8], w_q[8]));
        w_q[10] <= 32'(ONE_Q30) - div_rcp(w_q[9], RCP_6, SH_6);
        w_q[11] <= (sv > 34'(ONE_Q30)) ? 32'(ONE_Q30) : 32'(sv);
        c_q     <= 8'(cp >> FRAC);
      end
    end

    assign chan[l] = c_q;
  end

  logic [23:0] pix_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pix_q <= il_q[LN-1] ? 24'h0 : {chan[0], chan[1], chan[2]};
    end
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = pix_q;

  `SECP_ASSERT_NOW(a_mag_log_pos, v1, l1 >= 37'sh0_8000_0000, "log2 of magnitude below 2")
  `SECP_ASSERT_NOW(a_ln_nonzero, vb_q, m_q != '0, "ln of magnitude is zero")
  `SECP_ASSERT_NEXT(a_stall_freeze, !en, vo_q && $stable(pix_q), "output moved during stall")

endmodule
`default_nettype wire
